>>> src/kcl_pkg.sv
// Shared constants, codes and types of the keypad code lock controller.
`default_nettype none

package kcl_pkg;

   localparam int CODE_LENGTH = 4;
   localparam int ENTRY_DEPTH = 2 * CODE_LENGTH + 1;
   localparam int ENTRY_IDX_W = $clog2(ENTRY_DEPTH);

   localparam int KEY_W    = 3;
   localparam int POS_W    = 5;
   localparam int TRIES_W  = 4;
   localparam int TICKS_W  = 16;
   localparam int STATUS_W = 3;
   localparam int KIND_W   = 2;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_W-1:0] KEY_HASH = 3'd4;

   localparam logic [TRIES_W-1:0] TRIES_SAT         = 4'd15;
   localparam logic [TRIES_W-1:0] MAX_TRIES_RESET   = 4'd5;
   localparam logic [TICKS_W-1:0] LOCKOUT_RESET     = 16'd120;

   localparam logic CSR_MAX_TRIES     = 1'b0;
   localparam logic CSR_LOCKOUT_TICKS = 1'b1;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Item classes decided in the front end.
   localparam logic [KIND_W-1:0] KIND_KEY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_COLLECT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNLOCK     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_WRONG      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LOCK_START = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LOCK_END   = 3'd5;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      key_type           key;
   } kcl_item_type;

   // Packed so that status lands in the lowest bits.
   typedef struct packed {
      logic [POS_W-1:0]    keys_entered;
      logic [TRIES_W-1:0]  failed_tries;
      logic                code_changed;
      logic                change_mode;
      logic [STATUS_W-1:0] status;
   } kcl_result_type;

   localparam int RESULT_W = $bits(kcl_result_type);

endpackage

`default_nettype wire

>>> src/keypad_code_lock_controller.sv
// Keypad code lock controller: top level joining front end, queue and back end.
//
// Use: key events and time ticks arrive as request transfers (req_tuser 0 for a key,
// 1 for a tick, the key code in req_tdata). Every request gives exactly one response
// transfer carrying the status, the change-mode flag, the code-changed flag, the
// failed-try count and the number of keys held in the current entry.
// Configuration (max tries at index 0, lockout ticks at index 1) is written through
// the csr_ channel, which is always ready; write it only while the block is idle.
// Path: a request is held in the front register, then in a queue slot, and its response
// is valid from the back-end result register.
// Throughput: one request per cycle while rsp_tready stays high; the back end decides each
// item combinationally, with the whole code compare done in parallel.
// Reset: synchronous, active high; restores code "0123", five tries, 120 lockout ticks,
// and clears the entry, the try count and any lockout. No clearing pass is needed.
// Stalls: while rsp_tready is low the result register holds, the two-entry queue and
// the front register fill, and only then does req_tready fall.
`default_nettype none

module keypad_code_lock_controller
   import kcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [2:0] key_code, [7:3] zero
   input  wire logic                  req_tuser,   // [0] command
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [2:0] status, [3] change_mode, [4] code_changed, [8:5] failed_tries,
   // [13:9] keys_entered, [15:14] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic                  csr_index,
   input  wire logic [TICKS_W-1:0]    csr_data
);

   logic           front_valid, front_ready;
   kcl_item_type   front_item;
   logic           queue_valid, queue_ready;
   kcl_item_type   queue_item;
   kcl_result_type result;

   assign csr_ready = 1'b1;

   kcl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   kcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   kcl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {(RSP_DATA_W - RESULT_W)'(0), result};

endmodule

`default_nettype wire

>>> src/kcl_front.sv
// Front end: takes request transfers, classifies them and registers them.
`default_nettype none

module kcl_front
   import kcl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       item_valid,
   input  wire logic                  item_ready,
   output kcl_item_type               item
);

   logic         valid_ff, valid_in;
   kcl_item_type item_ff, item_in;
   kcl_item_type classified;
   key_type      key;

   assign key = req_tdata[KEY_W-1:0];

   always_comb begin
      classified.key = key;
      if (req_tuser == CMD_TICK) begin
         classified.kind = KIND_TICK;
      end else if (key > KEY_HASH) begin
         classified.kind = KIND_BAD;
      end else begin
         classified.kind = KIND_KEY;
      end
   end

   assign req_tready = !valid_ff || item_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         item_in  = classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> src/kcl_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none

module kcl_queue
   import kcl_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire kcl_item_type push_item,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output kcl_item_type      pop_item
);

   kcl_item_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;
   logic                    push, pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> src/kcl_back.sv
// Back end: lock state, code compare, try and lockout counting, result register.
`default_nettype none

module kcl_back
   import kcl_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_index,
   input  wire logic [TICKS_W-1:0]   csr_data,
   input  wire logic                 item_valid,
   output logic                      item_ready,
   input  wire kcl_item_type         item,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output kcl_result_type            result
);

   logic [TRIES_W-1:0] max_tries_ff, max_tries_in;
   logic [TICKS_W-1:0] lockout_ticks_ff, lockout_ticks_in;

   key_type            stored_ff [CODE_LENGTH];
   key_type            stored_in [CODE_LENGTH];
   key_type            entry_keys_ff [ENTRY_DEPTH];
   key_type            entry_keys_in [ENTRY_DEPTH];
   key_type            keys_now [ENTRY_DEPTH];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               changing_ff, changing_in;
   logic [TRIES_W-1:0] tries_ff, tries_in;
   logic [TICKS_W-1:0] lockout_ff, lockout_in;

   logic               rsp_valid_ff, rsp_valid_in;
   kcl_result_type     result_ff, result_in;

   logic                   take;
   logic [ENTRY_IDX_W-1:0] pos_idx;
   logic                   plain_ok, old_ok, new_ok;

   assign take       = item_valid && (!rsp_valid_ff || rsp_tready);
   assign item_ready = take;
   assign pos_idx    = pos_ff[ENTRY_IDX_W-1:0];

   // Entry with the current key written in, and the three fixed compares on it.
   always_comb begin
      keys_now          = entry_keys_ff;
      keys_now[pos_idx] = item.key;
      plain_ok = 1'b1;
      old_ok   = 1'b1;
      new_ok   = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (keys_now[ENTRY_IDX_W'(i)] != stored_ff[i]) begin
            plain_ok = 1'b0;
         end
         if (keys_now[ENTRY_IDX_W'(i + 1)] != stored_ff[i]) begin
            old_ok = 1'b0;
         end
         if (keys_now[ENTRY_IDX_W'(i + CODE_LENGTH + 1)] != stored_ff[i]) begin
            new_ok = 1'b0;
         end
      end
   end

   always_comb begin
      logic               changing_now;
      logic [POS_W-1:0]   pos_inc;
      logic               done;
      logic               do_change;
      logic               match;
      logic [TRIES_W-1:0] tries_inc;
      logic [STATUS_W-1:0] status;
      logic               changed;

      max_tries_in     = max_tries_ff;
      lockout_ticks_in = lockout_ticks_ff;
      stored_in        = stored_ff;
      entry_keys_in    = entry_keys_ff;
      pos_in           = pos_ff;
      changing_in      = changing_ff;
      tries_in         = tries_ff;
      lockout_in       = lockout_ff;
      status           = ST_COLLECT;
      changed          = 1'b0;
      changing_now     = changing_ff || (pos_ff == '0 && item.key == KEY_HASH);
      pos_inc          = pos_ff + 1'b1;
      done             = changing_now ? (pos_inc >= POS_W'(ENTRY_DEPTH))
                                      : (pos_inc >= POS_W'(CODE_LENGTH));
      do_change        = changing_now && old_ok
                         && keys_now[ENTRY_IDX_W'(CODE_LENGTH + 1)] != KEY_HASH;
      match            = changing_now ? (do_change || new_ok) : plain_ok;
      tries_inc        = (tries_ff == TRIES_SAT) ? tries_ff : tries_ff + 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_TRIES:     max_tries_in     = csr_data[TRIES_W-1:0];
            CSR_LOCKOUT_TICKS: lockout_ticks_in = csr_data;
            default: ;
         endcase
      end

      if (take) begin
         unique case (item.kind)
            KIND_TICK: begin
               if (lockout_ff != '0) begin
                  lockout_in = lockout_ff - 1'b1;
                  if (lockout_ff == TICKS_W'(1)) begin
                     tries_in = '0;
                     status   = ST_LOCK_END;
                  end
               end
            end
            KIND_BAD: begin
               if (lockout_ff != '0) begin
                  status = ST_IGNORED;
               end
            end
            KIND_KEY: begin
               if (lockout_ff != '0) begin
                  status = ST_IGNORED;
               end else begin
                  entry_keys_in = keys_now;
                  if (done) begin
                     if (do_change) begin
                        for (int i = 0; i < CODE_LENGTH; i++) begin
                           stored_in[i] = keys_now[ENTRY_IDX_W'(i + CODE_LENGTH + 1)];
                        end
                        changed = 1'b1;
                     end
                     pos_in      = '0;
                     changing_in = 1'b0;
                     if (match) begin
                        tries_in = '0;
                        status   = ST_UNLOCK;
                     end else begin
                        tries_in = tries_inc;
                        if (tries_inc >= max_tries_ff) begin
                           lockout_in = (lockout_ticks_ff == '0) ? TICKS_W'(1)
                                                                 : lockout_ticks_ff;
                           status     = ST_LOCK_START;
                        end else begin
                           status = ST_WRONG;
                        end
                     end
                  end else begin
                     pos_in      = pos_inc;
                     changing_in = changing_now;
                  end
               end
            end
            default: ;
         endcase
      end

      result_in.status       = status;
      result_in.change_mode  = changing_in;
      result_in.code_changed = changed;
      result_in.failed_tries = tries_in;
      result_in.keys_entered = pos_in;

      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tries_ff     <= MAX_TRIES_RESET;
         lockout_ticks_ff <= LOCKOUT_RESET;
         for (int i = 0; i < CODE_LENGTH; i++) begin
            stored_ff[i] <= KEY_W'(i);
         end
         pos_ff           <= '0;
         changing_ff      <= 1'b0;
         tries_ff         <= '0;
         lockout_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         max_tries_ff     <= max_tries_in;
         lockout_ticks_ff <= lockout_ticks_in;
         stored_ff        <= stored_in;
         pos_ff           <= pos_in;
         changing_ff      <= changing_in;
         tries_ff         <= tries_in;
         lockout_ff       <= lockout_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Entry keys are only read back after being written in the same entry.
   always_ff @(posedge clock) begin
      entry_keys_ff <= entry_keys_in;
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign result     = result_ff;

endmodule

`default_nettype wire

>>> src/kcl_checker.sv
// Port-level assertions on the controller's response channel, bound to the top level.
`default_nettype none

module kcl_checker
   import kcl_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   kcl_result_type res;

   assign res = kcl_result_type'(rsp_tdata[RESULT_W-1:0]);

   // No response may be left over from before a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res.status <= ST_LOCK_END)
      else $error("undefined status code");

   // An unlock completes the entry and clears the tries.
   a_unlock_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.status == ST_UNLOCK
      |-> res.failed_tries == '0 && res.keys_entered == '0 && !res.change_mode)
      else $error("unlock left entry or tries behind");

   // A lockout only starts on a completed, failed entry.
   a_lockout_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.status == ST_LOCK_START
      |-> res.failed_tries != '0 && res.keys_entered == '0 && !res.change_mode)
      else $error("lockout started without a completed failure");

endmodule

bind keypad_code_lock_controller kcl_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
